/* hw/rtl/pklt_pkg.sv */
// ----------------------------------------------------------------------------
// pklt_pkg
// Shared types and constants of the pair-keyed lookup table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pklt_pkg;

    // Default table depth and the fixed field widths.
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int MAX_LISTED      = 32;
    localparam int KEY_W           = 32;
    localparam int LIMIT_W         = 6;
    localparam int MODE_W          = 3;

    // A key of zero marks a null handle; a deleted entry has both keys null.
    localparam logic [KEY_W-1:0] NULL_KEY = '0;

    // Request codes.
    localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COUNT_ID   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIST_ID    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_COUNT_VIEW = 3'd5;
    localparam logic [MODE_W-1:0] MODE_LIST_VIEW  = 3'd6;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Compare results for one table entry against the request keys.
    typedef struct packed {
        logic pair_hit;
        logic is_free;
        logic id_sel;
        logic view_sel;
    } t_match;

endpackage : pklt_pkg

`default_nettype wire

/* hw/rtl/pklt_match.sv */
// ----------------------------------------------------------------------------
// pklt_match
// Key comparator shared by every scan step: compares one stored entry with
// the keys of the current request.
// ----------------------------------------------------------------------------
`default_nettype none

module pklt_match
    import pklt_pkg::*;
(
    input  wire logic [KEY_W-1:0] i_entry_view,
    input  wire logic [KEY_W-1:0] i_entry_id,
    input  wire logic [KEY_W-1:0] i_req_view,
    input  wire logic [KEY_W-1:0] i_req_id,
    output t_match                o_match
);

    logic w_view_eq;
    logic w_id_eq;

    // The two compares feed the pair, id and view flags; the free flag compares with the null key.
    assign w_view_eq = (i_entry_view == i_req_view);
    assign w_id_eq   = (i_entry_id == i_req_id);

    always_comb begin
        o_match.pair_hit = w_view_eq && w_id_eq;
        o_match.is_free  = (i_entry_view == NULL_KEY) && (i_entry_id == NULL_KEY);
        o_match.id_sel   = w_id_eq && (i_entry_view != NULL_KEY);
        o_match.view_sel = w_view_eq;
    end

endmodule : pklt_match

`default_nettype wire

/* hw/rtl/pair_keyed_lookup_table_unit.sv */
// ----------------------------------------------------------------------------
// pair_keyed_lookup_table_unit
// Table of (view, id) keyed objects searched by an in-order scan.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request code,
//   tdata the two keys, the object and the list limit. Results leave on the
//   m_axis channel: tdata is the value, tuser flags a dropped insert and
//   tlast marks the final result of a request.
//   One request is handled at a time; s_axis_tready is high only while the
//   block is idle. The scan reads one table entry per cycle through the
//   single read port of the entry memory and one shared key comparator,
//   except while a list request waits for the output register; a match
//   ends the scan of an insert, lookup or delete early. Every result of a
//   request is registered in the output register. When the receiver stalls,
//   a list request holds its scan until the output register is free again;
//   nothing is dropped.
//   Reset empties the table (the high-water mark goes to zero) and clears
//   the output valid flag; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_keyed_lookup_table_unit
    import pklt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Request channel.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: view_key[31:0], id_key[63:32], object_value[95:64],
    // list_limit[101:96], zero fill[103:102].
    input  wire logic [103:0] s_axis_tdata,
    // tuser: mode[2:0].
    input  wire logic [2:0]   s_axis_tuser,
    // Result channel.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: value[31:0].
    output logic [31:0]       m_axis_tdata,
    // tuser: table_full[0].
    output logic [0:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Entry memory.
    logic [KEY_W-1:0] mem_view [TABLE_DEPTH];
    logic [KEY_W-1:0] mem_id   [TABLE_DEPTH];
    logic [KEY_W-1:0] mem_obj  [TABLE_DEPTH];

    // Control registers.
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_used;
    logic             r_o_valid;

    // Request and scan registers.
    logic [MODE_W-1:0]  r_mode;
    logic [KEY_W-1:0]   r_view;
    logic [KEY_W-1:0]   r_id;
    logic [KEY_W-1:0]   r_obj;
    logic [LIMIT_W-1:0] r_limit;
    logic [CNT_W-1:0]   r_chk;
    logic [CNT_W-1:0]   r_count;
    logic               r_found;
    logic [IDX_W-1:0]   r_slot;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_slot;
    logic [KEY_W-1:0]   r_value;
    logic [KEY_W-1:0]   r_rd_view;
    logic [KEY_W-1:0]   r_rd_id;
    logic [KEY_W-1:0]   r_rd_obj;

    // Output register payload.
    logic [KEY_W-1:0] r_o_data;
    logic             r_o_full;
    logic             r_o_last;

    // Combinational control.
    logic               w_accept;
    logic               w_out_free;
    logic               w_end;
    logic               w_is_list;
    logic               w_is_counting;
    logic               w_by_id;
    logic               w_sel;
    logic               w_stop_mode;
    logic               w_limit_hit;
    logic               w_eval;
    logic               w_adv;
    logic               w_scan_done;
    logic               w_emit_mid;
    logic               w_finish;
    logic               w_full;
    logic               w_key_we;
    logic               w_obj_we;
    logic               w_append;
    logic [IDX_W-1:0]   w_wr_addr;
    logic [CNT_W-1:0]   w_rd_cnt;
    logic [KEY_W-1:0]   w_final_value;
    logic [LIMIT_W-1:0] w_in_limit;
    t_match             w_match;

    // Key comparator for the entry currently read.
    pklt_match u_match (
        .i_entry_view (r_rd_view),
        .i_entry_id   (r_rd_id),
        .i_req_view   (r_view),
        .i_req_id     (r_id),
        .o_match      (w_match)
    );

    // Handshake and mode decode.
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_o_valid || m_axis_tready;
    assign w_end         = (r_chk == r_used);
    assign w_is_list     = (r_mode == MODE_LIST_ID) || (r_mode == MODE_LIST_VIEW);
    assign w_by_id       = (r_mode == MODE_LIST_ID) || (r_mode == MODE_COUNT_ID);
    assign w_is_counting = w_is_list || (r_mode == MODE_COUNT_ID)
                           || (r_mode == MODE_COUNT_VIEW);
    assign w_sel         = w_by_id ? w_match.id_sel : w_match.view_sel;
    assign w_stop_mode   = (r_mode == MODE_INSERT) || (r_mode == MODE_LOOKUP)
                           || (r_mode == MODE_DELETE);
    assign w_limit_hit   = w_is_list && (CMP_W'(r_count) == CMP_W'(r_limit));
    assign w_eval        = (r_state == ST_SCAN) && !w_end && !w_limit_hit;

    // Limits above the list maximum are clipped on entry.
    assign w_in_limit = (s_axis_tdata[101:96] > LIMIT_W'(MAX_LISTED))
                        ? LIMIT_W'(MAX_LISTED) : s_axis_tdata[101:96];

    // Sequencer outputs.
    always_comb begin
        w_adv       = 1'b0;
        w_scan_done = 1'b0;
        w_emit_mid  = 1'b0;
        w_finish    = 1'b0;
        case (r_state)
            ST_SCAN: begin
                if (!w_eval) begin
                    w_scan_done = 1'b1;
                end else if (w_stop_mode && w_match.pair_hit) begin
                    w_scan_done = 1'b1;
                end else if (w_is_list && w_sel) begin
                    w_emit_mid = w_out_free;
                    w_adv      = w_out_free;
                end else begin
                    w_adv = 1'b1;
                end
            end
            ST_FINISH: begin
                w_finish = w_out_free;
            end
            default: begin
                w_adv = 1'b0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_scan_done) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_finish) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Final step: where an insert lands, and the last result.
    always_comb begin
        w_full    = (r_mode == MODE_INSERT) && !r_found && !r_free_found
                    && (r_used == CNT_W'(TABLE_DEPTH));
        w_append  = w_finish && (r_mode == MODE_INSERT) && !r_found
                    && !r_free_found && !w_full;
        w_obj_we  = w_finish && (r_mode == MODE_INSERT) && !w_full;
        w_key_we  = w_obj_we || (w_finish && (r_mode == MODE_DELETE) && r_found);
        if (r_found) begin
            w_wr_addr = r_slot;
        end else if (r_free_found) begin
            w_wr_addr = r_free_slot;
        end else begin
            w_wr_addr = r_used[IDX_W-1:0];
        end
        if (r_mode == MODE_LOOKUP) begin
            w_final_value = r_value;
        end else if (w_is_counting) begin
            w_final_value = KEY_W'(r_count);
        end else begin
            w_final_value = '0;
        end
    end

    // The read port follows the scan: entry zero on accept, the next entry on advance, else hold.
    always_comb begin
        if (w_accept) begin
            w_rd_cnt = '0;
        end else if (w_adv) begin
            w_rd_cnt = CNT_W'(r_chk + 1'b1);
        end else begin
            w_rd_cnt = r_chk;
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            mem_view[w_wr_addr] <= (r_mode == MODE_INSERT) ? r_view : NULL_KEY;
            mem_id[w_wr_addr]   <= (r_mode == MODE_INSERT) ? r_id : NULL_KEY;
        end
        if (w_obj_we) begin
            mem_obj[w_wr_addr] <= r_obj;
        end
        r_rd_view <= mem_view[w_rd_cnt[IDX_W-1:0]];
        r_rd_id   <= mem_id[w_rd_cnt[IDX_W-1:0]];
        r_rd_obj  <= mem_obj[w_rd_cnt[IDX_W-1:0]];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_used    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_append) begin
                r_used <= CNT_W'(r_used + 1'b1);
            end
            if (w_emit_mid || w_finish) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Request capture and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode       <= s_axis_tuser;
            r_view       <= s_axis_tdata[31:0];
            r_id         <= s_axis_tdata[63:32];
            r_obj        <= s_axis_tdata[95:64];
            r_limit      <= w_in_limit;
            r_chk        <= '0;
            r_count      <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_value      <= '0;
        end else if (w_eval) begin
            if (w_stop_mode && w_match.pair_hit) begin
                r_found <= 1'b1;
                r_slot  <= r_chk[IDX_W-1:0];
                r_value <= r_rd_obj;
            end else if ((r_mode == MODE_INSERT) && w_match.is_free && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_chk[IDX_W-1:0];
            end
            if (w_is_counting && w_sel && (!w_is_list || w_out_free)) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end
            if (w_adv) begin
                r_chk <= CNT_W'(r_chk + 1'b1);
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_emit_mid) begin
            r_o_data <= w_by_id ? r_rd_view : r_rd_id;
            r_o_full <= 1'b0;
            r_o_last <= 1'b0;
        end else if (w_finish) begin
            r_o_data <= w_final_value;
            r_o_full <= w_full;
            r_o_last <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_full;
    assign m_axis_tlast  = r_o_last;

    // The high-water mark never passes the table depth.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_DEPTH))
        else $error("high-water mark beyond table depth");

    // The scan never reads past the high-water mark.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_chk <= r_used))
        else $error("scan index beyond high-water mark");

    // The high-water mark grows by at most one entry per cycle.
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used == $past(r_used)) || (r_used == $past(r_used) + 1'b1))
        else $error("high-water mark jumped");

    // A dropped insert is always reported on a final result.
    a_full_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("table full flag on a non-final result");

    // Once the final result is loaded the block is ready again.
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> s_axis_tready)
        else $error("not idle after the final result");

endmodule : pair_keyed_lookup_table_unit

`default_nettype wire
